### src/lcse_pkg.sv
// Shared types, constants and helpers for the LED color store symbol encoder.
// Depends on nothing; every other file refers to it by scoped names.
package lcse_pkg;

    localparam int LED_COUNT   = 128;
    localparam int LEVEL_COUNT = 7;
    localparam int LED_ADDR_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int LEVEL_W     = 3;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Item kinds as they arrive on the input channel.
    localparam logic [2:0] KIND_SET    = 3'd0;
    localparam logic [2:0] KIND_STORED = 3'd1;
    localparam logic [2:0] KIND_OFF    = 3'd2;
    localparam logic [2:0] KIND_UP     = 3'd3;
    localparam logic [2:0] KIND_DOWN   = 3'd4;

    // Channel codes on the result channel, in emission order.
    localparam logic [1:0] CH_GREEN = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_SYMBOL_HIGH = 1'b0;
    localparam logic CFG_SYMBOL_LOW  = 1'b1;

    localparam logic [7:0] SYMBOL_HIGH_RESET = 8'd248;
    localparam logic [7:0] SYMBOL_LOW_RESET  = 8'd192;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_BUSY
    } back_state_t;

    // One classified encode request travelling from the front to the back.
    typedef struct packed {
        logic [6:0]         led;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [8:0]         brightness;
        logic [2:0]         shift;
        logic               off;
    } lcse_item_t;

    // Pre-divide shift for each brightness level.
    function automatic logic [2:0] prediv_shift(input logic [LEVEL_W-1:0] level);
        logic [2:0] sh;
        begin
            case (level)
                3'd0:    sh = 3'd7;
                3'd1:    sh = 3'd5;
                3'd2:    sh = 3'd4;
                3'd3:    sh = 3'd3;
                3'd4:    sh = 3'd2;
                3'd5:    sh = 3'd1;
                default: sh = 3'd0;
            endcase
            return sh;
        end
    endfunction

endpackage

### src/lcse_front.sv
// Front end: accepts input words, keeps the color store and brightness level,
// and turns encode words into queue entries. Depends on lcse_pkg.
module lcse_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_kind,
    input  logic [6:0]          s_led_index,
    input  logic [7:0]          s_red,
    input  logic [7:0]          s_green,
    input  logic [7:0]          s_blue,
    input  logic [8:0]          s_brightness,
    output logic                push_valid,
    input  logic                push_ready,
    output lcse_pkg::lcse_item_t push_item
);

    logic [23:0]                          mem [lcse_pkg::LED_COUNT];
    logic [lcse_pkg::LED_COUNT-1:0]       entry_valid_reg;
    logic [23:0]                          rdata_reg;
    logic                                 rvalid_reg;
    logic [lcse_pkg::LEVEL_W-1:0]         level_reg;
    logic [lcse_pkg::LEVEL_W-1:0]         level_next;
    logic                                 stg_valid_reg;
    logic                                 stg_valid_next;
    lcse_pkg::lcse_item_t                 stg_item_reg;
    logic                                 stg_use_mem_reg;
    logic                                 stg_in_range_reg;

    logic                                 accept;
    logic                                 in_range;
    logic                                 is_encode;
    logic                                 is_write;
    logic [lcse_pkg::LED_ADDR_W-1:0]      addr;

    assign s_ready  = !stg_valid_reg || push_ready;
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_led_index) < lcse_pkg::LED_COUNT);
    assign addr     = lcse_pkg::LED_ADDR_W'(s_led_index);

    always_comb begin
        is_encode  = 1'b0;
        is_write   = 1'b0;
        level_next = level_reg;
        unique case (s_kind) inside
            lcse_pkg::KIND_SET: begin
                is_encode = 1'b1;
                is_write  = in_range;
            end
            lcse_pkg::KIND_STORED, lcse_pkg::KIND_OFF: begin
                is_encode = 1'b1;
            end
            lcse_pkg::KIND_UP: begin
                if (32'(level_reg) + 1 < lcse_pkg::LEVEL_COUNT) begin
                    level_next = level_reg + 1'b1;
                end
            end
            lcse_pkg::KIND_DOWN: begin
                if (level_reg != '0) begin
                    level_next = level_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Color store: at most one write and one registered read per accepted word.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (is_write) begin
                mem[addr] <= {s_red, s_green, s_blue};
            end
            rdata_reg <= mem[addr];
        end
    end

    // Entries never written read as black.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (accept && is_write) begin
            entry_valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rvalid_reg <= entry_valid_reg[addr];
        end
    end

    assign stg_valid_next = (accept && is_encode) ? 1'b1 :
                            (push_ready ? 1'b0 : stg_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            if (accept) begin
                level_reg <= level_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_encode) begin
            stg_item_reg.led        <= s_led_index;
            stg_item_reg.red        <= s_red;
            stg_item_reg.green      <= s_green;
            stg_item_reg.blue       <= s_blue;
            stg_item_reg.brightness <= s_brightness;
            stg_item_reg.shift      <= lcse_pkg::prediv_shift(level_reg);
            stg_item_reg.off        <= (s_kind == lcse_pkg::KIND_OFF);
            stg_use_mem_reg         <= (s_kind == lcse_pkg::KIND_STORED);
            stg_in_range_reg        <= in_range;
        end
    end

    assign push_valid = stg_valid_reg;

    always_comb begin
        push_item = stg_item_reg;
        if (stg_use_mem_reg) begin
            if (stg_in_range_reg && rvalid_reg) begin
                push_item.red   = rdata_reg[23:16];
                push_item.green = rdata_reg[15:8];
                push_item.blue  = rdata_reg[7:0];
            end else begin
                push_item.red   = '0;
                push_item.green = '0;
                push_item.blue  = '0;
            end
        end
    end

endmodule

### src/lcse_fifo.sv
// Short queue of encode requests between the front and the back.
// Depends on lcse_pkg for the entry type and depth.
module lcse_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  lcse_pkg::lcse_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output lcse_pkg::lcse_item_t rd_item
);

    lcse_pkg::lcse_item_t              slot_reg [lcse_pkg::FIFO_DEPTH];
    logic [lcse_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [lcse_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [lcse_pkg::FIFO_CNT_W-1:0]   count_reg;
    logic [lcse_pkg::FIFO_CNT_W-1:0]   count_next;
    logic                              push;
    logic                              pop;

    assign wr_ready = (32'(count_reg) < lcse_pkg::FIFO_DEPTH);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == lcse_pkg::FIFO_DEPTH - 1) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == lcse_pkg::FIFO_DEPTH - 1) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= lcse_pkg::FIFO_DEPTH)
        else $error("queue count exceeds depth");

    a_pop_then_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not drop after a pop");

endmodule

### src/lcse_back.sv
// Back end: takes one queued request and emits its green, red and blue words,
// one per cycle while m_ready allows, through an output register. Depends on lcse_pkg.
module lcse_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  lcse_pkg::lcse_item_t q_item,
    input  logic [7:0]           symbol_high,
    input  logic [7:0]           symbol_low,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_led_id,
    output logic [1:0]           m_channel,
    output logic [63:0]          m_symbols,
    output logic                 m_last
);

    lcse_pkg::back_state_t  state_reg;
    lcse_pkg::back_state_t  state_next;
    lcse_pkg::lcse_item_t   item_reg;
    logic [1:0]             chan_reg;
    logic [1:0]             chan_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [6:0]             out_led_reg;
    logic [1:0]             out_chan_reg;
    logic [63:0]            out_sym_reg;
    logic                   out_last_reg;

    logic                   load_out;
    logic                   blank;
    logic [7:0]             blue_eff;
    logic [7:0]             chan_val;
    logic [16:0]            product;
    logic [7:0]             scaled;
    logic [7:0]             level_val;
    logic [63:0]            sym_word;

    always_comb begin
        load_out   = 1'b0;
        q_ready    = 1'b0;
        state_next = state_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            lcse_pkg::BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    state_next = lcse_pkg::BK_BUSY;
                    chan_next  = lcse_pkg::CH_GREEN;
                end
            end
            lcse_pkg::BK_BUSY: begin
                load_out = !out_valid_reg || m_ready;
                if (load_out) begin
                    if (chan_reg == lcse_pkg::CH_BLUE) begin
                        q_ready    = 1'b1;
                        chan_next  = lcse_pkg::CH_GREEN;
                        state_next = q_valid ? lcse_pkg::BK_BUSY : lcse_pkg::BK_IDLE;
                    end else begin
                        chan_next = chan_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = lcse_pkg::BK_IDLE;
            end
        endcase
    end

    // Channel value: product, saturate, pre-divide, blank, expand to symbol bytes.
    always_comb begin
        blank    = item_reg.off || (item_reg.brightness == '0) ||
                   ({item_reg.red, item_reg.green, item_reg.blue} == '0);
        blue_eff = (item_reg.blue == '0) ? 8'd1 : item_reg.blue;
        case (chan_reg)
            lcse_pkg::CH_GREEN: chan_val = item_reg.green;
            lcse_pkg::CH_RED:   chan_val = item_reg.red;
            default:            chan_val = blue_eff;
        endcase
        product   = {9'd0, chan_val} * {8'd0, item_reg.brightness};
        scaled    = product[16] ? 8'hFF : product[15:8];
        level_val = blank ? 8'd0 : (scaled >> item_reg.shift);
        for (int i = 0; i < 8; i++) begin
            sym_word[8*i +: 8] = level_val[i] ? symbol_high : symbol_low;
        end
    end

    assign out_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcse_pkg::BK_IDLE;
            chan_reg      <= lcse_pkg::CH_GREEN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            item_reg <= q_item;
        end
        if (load_out) begin
            out_led_reg  <= item_reg.led;
            out_chan_reg <= chan_reg;
            out_sym_reg  <= sym_word;
            out_last_reg <= (chan_reg == lcse_pkg::CH_BLUE);
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_led_id  = out_led_reg;
    assign m_channel = out_chan_reg;
    assign m_symbols = out_sym_reg;
    assign m_last    = out_last_reg;

    a_last_is_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_channel == lcse_pkg::CH_BLUE)))
        else $error("last flag does not match blue channel");

    a_green_then_red: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_channel == lcse_pkg::CH_GREEN) |=>
        (m_valid && m_channel == lcse_pkg::CH_RED))
        else $error("red word did not follow green");

    a_red_then_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_channel == lcse_pkg::CH_RED) |=>
        (m_valid && m_channel == lcse_pkg::CH_BLUE))
        else $error("blue word did not follow red");

    a_idle_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lcse_pkg::BK_IDLE) |-> (chan_reg == lcse_pkg::CH_GREEN))
        else $error("channel counter not at green while idle");

endmodule

### src/led_color_store_symbol_encoder.sv
// Top level of the LED color store symbol encoder: configuration registers and
// the front, queue and back. Depends on lcse_pkg, lcse_front, lcse_fifo, lcse_back.
//
// Use: the input channel (s_*) takes one word per command. Kind 0 stores a
// color for an LED and encodes it, kind 1 encodes the stored color, kind 2
// encodes the LED as off, kinds 3 and 4 step the brightness level up or down.
// Each encode word yields three result words on the m_* channel, green, red
// and blue in that order, with m_last set on blue. Every result word carries
// eight SPI symbol bytes, the symbol for bit 7 of the channel in the top byte.
// The configuration channel (cfg_*) sets the symbol bytes for one and zero
// bits; it is always ready and is meant to be written while the block is idle.
// An accepted input word passes the front stage register, the queue, the back
// end's request register and its output register before m_valid rises. The
// back end emits one result word per cycle while m_ready is high, and level
// words stop at the front and never reach the queue. The front stage and a
// two-entry queue let up to three encode words be accepted while earlier
// results are still going out.
// Reset (aresetn low, synchronous) clears the queue, the brightness level to
// its dimmest setting, the symbol bytes to their defaults and every LED in the
// store to black. When the receiver holds m_ready low, the current result
// word is held, the back end stops, and the input stalls once the queue fills.
module led_color_store_symbol_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [6:0]  s_led_index,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [8:0]  s_brightness,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_led_id,
    output logic [1:0]  m_channel,
    output logic [63:0] m_symbols,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]           symbol_high_reg;
    logic [7:0]           symbol_low_reg;

    logic                 push_valid;
    logic                 push_ready;
    lcse_pkg::lcse_item_t push_item;
    logic                 q_valid;
    logic                 q_ready;
    lcse_pkg::lcse_item_t q_item;

    // Configuration writes land in the symbol registers directly, so the port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_high_reg <= lcse_pkg::SYMBOL_HIGH_RESET;
            symbol_low_reg  <= lcse_pkg::SYMBOL_LOW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lcse_pkg::CFG_SYMBOL_HIGH: symbol_high_reg <= cfg_data;
                lcse_pkg::CFG_SYMBOL_LOW:  symbol_low_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: classifies words, updates the store and level, builds requests.
    lcse_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_led_index  (s_led_index),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_brightness (s_brightness),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    // Queue: decouples the front from a stalled back end.
    lcse_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // Back: scales each channel and expands it into symbol bytes.
    lcse_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .symbol_high  (symbol_high_reg),
        .symbol_low   (symbol_low_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_led_id     (m_led_id),
        .m_channel    (m_channel),
        .m_symbols    (m_symbols),
        .m_last       (m_last)
    );

endmodule
